>>> rtl/pcd_pkg.sv
// Shared widths, constants and the context record of the divisor calculator.
`default_nettype none
package pcd_pkg;
   localparam int TGT_W  = 27;
   localparam int OSC_W  = 25;
   localparam int MULT_W = 10;
   localparam int DIV_W  = 9;
   localparam int ACH_W  = 28;
   localparam int NUM_W  = 36;
   localparam int NUM_W1 = NUM_W + 1;
   localparam int DEN_W  = 27;
   localparam int QUO_W  = 28;

   localparam logic [28:0]      VCO_HIGH   = 29'd480000000;
   localparam logic [28:0]      VCO_LOW    = 29'd288000000;
   localparam logic [TGT_W-1:0] VCO_SWITCH = 27'd96000000;
   localparam logic [OSC_W-1:0] HIGH_RANGE = 25'd18000000;
   localparam logic [OSC_W-1:0] IRC_FREQ   = 25'd4000000;
   localparam logic [QUO_W-1:0] MULT_MAX   = 28'd512;
   localparam logic [QUO_W-1:0] MULT_MIN   = 28'd6;
   localparam logic [QUO_W-1:0] DIV_MAX    = 28'd256;
   localparam logic [QUO_W-1:0] DIV_MIN    = 28'd3;
   localparam logic [QUO_W-1:0] DIV_ONE    = 28'd1;
   localparam logic [ACH_W-1:0] ACH_MAX    = 28'hFFFFFFF;

   typedef struct packed {
      logic              use_pll;
      logic              sel;
      logic              hr;
      logic [OSC_W-1:0]  src;
      logic [MULT_W-1:0] mult;
      logic [DIV_W-1:0]  div;
   } ctx_type;
endpackage
`default_nettype wire

>>> rtl/pcd_front.sv
// Input decode: source choice, VCO choice and the operands of the first divisions.
`default_nettype none
module pcd_front (
   input  wire logic [pcd_pkg::TGT_W-1:0] target_freq,
   input  wire logic [pcd_pkg::OSC_W-1:0] osc_freq,
   output pcd_pkg::ctx_type               ctx,
   output logic [pcd_pkg::NUM_W-1:0]      mult_num,
   output logic [pcd_pkg::DEN_W-1:0]      mult_den,
   output logic [pcd_pkg::NUM_W-1:0]      div_num,
   output logic [pcd_pkg::DEN_W-1:0]      div_den
);
   logic [pcd_pkg::TGT_W-1:0] tgt;
   logic [pcd_pkg::OSC_W-1:0] src;
   logic [28:0]               vco;
   logic                      pll;

   always_comb begin
      // a zero target counts as 1 Hz
      tgt = (target_freq == '0) ? pcd_pkg::TGT_W'(1) : target_freq;
      src = (osc_freq != '0) ? osc_freq : pcd_pkg::IRC_FREQ;
      vco = (tgt > pcd_pkg::VCO_SWITCH) ? pcd_pkg::VCO_HIGH : pcd_pkg::VCO_LOW;
      pll = tgt > pcd_pkg::TGT_W'(src);
      ctx.use_pll = pll;
      ctx.sel     = osc_freq != '0;
      ctx.hr      = osc_freq > pcd_pkg::HIGH_RANGE;
      ctx.src     = src;
      ctx.mult    = '0;
      ctx.div     = '0;
      mult_num = pcd_pkg::NUM_W'(vco) + pcd_pkg::NUM_W'(src);
      mult_den = pcd_pkg::DEN_W'({src, 1'b0});
      div_num  = (pll ? pcd_pkg::NUM_W'(vco) : pcd_pkg::NUM_W'(src))
                 + pcd_pkg::NUM_W'(tgt >> 1);
      div_den  = tgt;
   end
endmodule
`default_nettype wire

>>> rtl/pcd_div.sv
// Restoring divider, one quotient bit per stage, with overflow flag and context.
`default_nettype none
module pcd_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        valid_i,
   input  wire logic [pcd_pkg::NUM_W-1:0]   num_i,
   input  wire logic [pcd_pkg::DEN_W-1:0]   den_i,
   input  wire pcd_pkg::ctx_type            ctx_i,
   output logic                             valid_o,
   output logic [pcd_pkg::QUO_W-1:0]        quo_o,
   output logic                             ovf_o,
   output pcd_pkg::ctx_type                 ctx_o
);
   localparam int N = pcd_pkg::QUO_W;

   logic [pcd_pkg::NUM_W-1:0] rem_ff   [0:N];
   logic [pcd_pkg::DEN_W-1:0] den_ff   [0:N];
   logic [pcd_pkg::QUO_W-1:0] quo_ff   [0:N];
   logic                      ovf_ff   [0:N];
   logic                      valid_ff [0:N];
   pcd_pkg::ctx_type          ctx_ff   [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= valid_i;
      end
      if (en) begin
         rem_ff[0] <= num_i;
         den_ff[0] <= den_i;
         quo_ff[0] <= '0;
         ctx_ff[0] <= ctx_i;
         // quotient too wide for the stages when num / 2^N reaches den
         ovf_ff[0] <= pcd_pkg::DEN_W'(num_i[pcd_pkg::NUM_W-1:N]) >= den_i;
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_step
      localparam int B = N - 1 - s;
      logic [pcd_pkg::NUM_W1-1:0] hi;
      logic                       take;
      logic [pcd_pkg::NUM_W-1:0]  rem_in;
      logic [pcd_pkg::QUO_W-1:0]  quo_in;

      always_comb begin
         hi     = pcd_pkg::NUM_W1'(rem_ff[s] >> B);
         take   = hi >= pcd_pkg::NUM_W1'(den_ff[s]);
         rem_in = take ? rem_ff[s] - (pcd_pkg::NUM_W'(den_ff[s]) << B) : rem_ff[s];
         quo_in    = quo_ff[s];
         quo_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (en) begin
            rem_ff[s+1] <= rem_in;
            den_ff[s+1] <= den_ff[s];
            quo_ff[s+1] <= quo_in;
            ovf_ff[s+1] <= ovf_ff[s];
            ctx_ff[s+1] <= ctx_ff[s];
         end
      end
   end

   assign valid_o = valid_ff[N];
   assign quo_o   = quo_ff[N];
   assign ovf_o   = ovf_ff[N];
   assign ctx_o   = ctx_ff[N];
endmodule
`default_nettype wire

>>> rtl/pll_clock_divisor_calc_top.sv
// Top level of the PLL and core clock divisor calculator.
// Throughput: one word per cycle while the response word is not stalled; two
// 28-stage bit-per-stage divider pipelines in series, with the multiplier/divider
// pair running side by side in the first.
// The whole pipeline holds while the response word is stalled.
// Reset clears all valid bits; no response is pending after reset.
`default_nettype none
module pll_clock_divisor_calc_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [pcd_pkg::TGT_W-1:0]   req_target_freq,
   input  wire logic [pcd_pkg::OSC_W-1:0]   req_osc_freq,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_use_pll,
   output logic [pcd_pkg::MULT_W-1:0]       rsp_pll_mult,
   output logic [pcd_pkg::DIV_W-1:0]        rsp_core_div,
   output logic                             rsp_clock_source,
   output logic                             rsp_osc_high_range,
   output logic [pcd_pkg::ACH_W-1:0]        rsp_achieved_freq
);
   logic en;
   pcd_pkg::ctx_type          f_ctx, m_ctx, a_ctx;
   logic [pcd_pkg::NUM_W-1:0] f_mnum, f_dnum;
   logic [pcd_pkg::DEN_W-1:0] f_mden, f_dden;
   logic                      m_valid, m_ovf, d_ovf, a_valid, a_ovf;
   logic [pcd_pkg::QUO_W-1:0] m_quo, d_quo, a_quo;

   logic                      mid_valid_ff;
   pcd_pkg::ctx_type          mid_ctx_ff, mid_ctx_in;
   logic [pcd_pkg::NUM_W-1:0] mid_num_ff, mid_num_in;
   logic [pcd_pkg::QUO_W-1:0] mraw, draw;

   logic                      rsp_valid_ff;
   pcd_pkg::ctx_type          rsp_ctx_ff;
   logic [pcd_pkg::ACH_W-1:0] rsp_ach_ff, rsp_ach_in;

   // advance everything unless a finished word is held
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   pcd_front u_front (
      .target_freq (req_target_freq),
      .osc_freq    (req_osc_freq),
      .ctx         (f_ctx),
      .mult_num    (f_mnum),
      .mult_den    (f_mden),
      .div_num     (f_dnum),
      .div_den     (f_dden)
   );

   pcd_div u_mult_div (
      .clock (clock), .reset (reset), .en (en), .valid_i (req_valid),
      .num_i (f_mnum), .den_i (f_mden), .ctx_i (f_ctx),
      .valid_o (m_valid), .quo_o (m_quo), .ovf_o (m_ovf), .ctx_o (m_ctx)
   );

   pcd_div u_core_div (
      .clock (clock), .reset (reset), .en (en), .valid_i (req_valid),
      .num_i (f_dnum), .den_i (f_dden), .ctx_i (f_ctx),
      .valid_o (), .quo_o (d_quo), .ovf_o (d_ovf), .ctx_o ()
   );

   always_comb begin
      mid_ctx_in = m_ctx;
      mraw = m_ovf ? pcd_pkg::MULT_MAX : m_quo;
      draw = d_ovf ? pcd_pkg::DIV_MAX : d_quo;
      if (m_ctx.use_pll) begin
         if (mraw > pcd_pkg::MULT_MAX) mraw = pcd_pkg::MULT_MAX;
         if (mraw < pcd_pkg::MULT_MIN) mraw = pcd_pkg::MULT_MIN;
         if (draw < pcd_pkg::DIV_MIN)  draw = pcd_pkg::DIV_MIN;
         if (draw > pcd_pkg::DIV_MAX)  draw = pcd_pkg::DIV_MAX;
         mid_ctx_in.mult = pcd_pkg::MULT_W'(mraw);
      end else begin
         if (draw > pcd_pkg::DIV_MAX)  draw = pcd_pkg::DIV_MAX;
         if (draw < pcd_pkg::DIV_ONE)  draw = pcd_pkg::DIV_ONE;
         mid_ctx_in.mult = '0;
      end
      mid_ctx_in.div = pcd_pkg::DIV_W'(draw);
      mid_num_in = m_ctx.use_pll
                   ? pcd_pkg::NUM_W'(m_ctx.src) * pcd_pkg::NUM_W'({mid_ctx_in.mult, 1'b0})
                   : pcd_pkg::NUM_W'(m_ctx.src);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (en) begin
         mid_valid_ff <= m_valid;
      end
      if (en) begin
         mid_ctx_ff <= mid_ctx_in;
         mid_num_ff <= mid_num_in;
      end
   end

   pcd_div u_ach_div (
      .clock (clock), .reset (reset), .en (en), .valid_i (mid_valid_ff),
      .num_i (mid_num_ff), .den_i (pcd_pkg::DEN_W'(mid_ctx_ff.div)), .ctx_i (mid_ctx_ff),
      .valid_o (a_valid), .quo_o (a_quo), .ovf_o (a_ovf), .ctx_o (a_ctx)
   );

   assign rsp_ach_in = a_ovf ? pcd_pkg::ACH_MAX : pcd_pkg::ACH_W'(a_quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= a_valid;
      end
      if (en) begin
         rsp_ctx_ff <= a_ctx;
         rsp_ach_ff <= rsp_ach_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_use_pll        = rsp_ctx_ff.use_pll;
   assign rsp_pll_mult       = rsp_ctx_ff.mult;
   assign rsp_core_div       = rsp_ctx_ff.div;
   assign rsp_clock_source   = rsp_ctx_ff.sel;
   assign rsp_osc_high_range = rsp_ctx_ff.hr;
   assign rsp_achieved_freq  = rsp_ach_ff;
endmodule
`default_nettype wire

>>> rtl/pcd_check.sv
// Port-level checks for the divisor calculator, bound to the top level.
`default_nettype none
module pcd_check (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic                      rsp_use_pll,
   input wire logic [pcd_pkg::MULT_W-1:0] rsp_pll_mult,
   input wire logic [pcd_pkg::DIV_W-1:0]  rsp_core_div,
   input wire logic                      rsp_clock_source,
   input wire logic                      rsp_osc_high_range,
   input wire logic [pcd_pkg::ACH_W-1:0]  rsp_achieved_freq
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_achieved_freq)
      && $stable(rsp_core_div) && $stable(rsp_pll_mult))
      else $error("stalled response word changed");

   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response held");

   a_direct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_use_pll |-> rsp_pll_mult == '0 && rsp_core_div != '0)
      else $error("direct path word malformed");

   a_pll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_pll |-> rsp_pll_mult >= 10'd6 && rsp_pll_mult <= 10'd512
      && rsp_core_div >= 9'd3 && rsp_core_div <= 9'd256)
      else $error("PLL settings out of range");

   a_irc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_clock_source |-> !rsp_osc_high_range)
      else $error("high range flagged on internal oscillator");
endmodule

bind pll_clock_divisor_calc_top pcd_check u_pcd_check (
   .clock (clock), .reset (reset), .req_stall (req_stall),
   .rsp_valid (rsp_valid), .rsp_stall (rsp_stall), .rsp_use_pll (rsp_use_pll),
   .rsp_pll_mult (rsp_pll_mult), .rsp_core_div (rsp_core_div),
   .rsp_clock_source (rsp_clock_source), .rsp_osc_high_range (rsp_osc_high_range),
   .rsp_achieved_freq (rsp_achieved_freq)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the PLL and core clock divisor calculator.
`default_nettype none

class divisor_scoreboard;
   typedef struct {
      logic        use_pll;
      logic [9:0]  mult;
      logic [8:0]  div;
      logic        sel;
      logic        hr;
      logic [27:0] ach;
   } clk_plan_type;

   clk_plan_type plan_q[$];
   int           mismatches;

   function void note_request(logic [26:0] tgt_in, logic [24:0] osc_in);
      longint unsigned tgt, src, vco, m, d, a;
      clk_plan_type p;
      tgt = 64'(tgt_in);
      if (tgt == 0) tgt = 1;
      p.sel = (osc_in != 0);
      src   = p.sel ? 64'(osc_in) : 64'd4000000;
      p.hr  = p.sel && (osc_in > 25'd18000000);
      vco   = (tgt > 96000000) ? 64'd480000000 : 64'd288000000;
      m     = 0;
      if (tgt > src) begin
         p.use_pll = 1;
         m = (vco + src) / (src * 2);
         if (m > 512) m = 512;
         if (m < 6) m = 6;
         d = (vco + tgt / 2) / tgt;
         if (d < 3) d = 3;
         if (d > 256) d = 256;
         a = src * 2 * m / d;
      end else begin
         p.use_pll = 0;
         d = (src + tgt / 2) / tgt;
         if (d > 256) d = 256;
         if (d < 1) d = 1;
         a = src / d;
      end
      if (a > 64'hFFFFFFF) a = 64'hFFFFFFF;
      p.mult = m[9:0];
      p.div  = d[8:0];
      p.ach  = a[27:0];
      plan_q.push_back(p);
   endfunction

   task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatches++;
   endtask

   task check_response(logic up, logic [9:0] m, logic [8:0] d, logic s,
                       logic h, logic [27:0] a);
      clk_plan_type p;
      if (plan_q.size() == 0) begin
         report("unexpected word", 1, 0);
         return;
      end
      p = plan_q.pop_front();
      if (up !== p.use_pll) report("use_pll", 64'(up), 64'(p.use_pll));
      if (m !== p.mult) report("pll_mult", 64'(m), 64'(p.mult));
      if (d !== p.div) report("core_div", 64'(d), 64'(p.div));
      if (s !== p.sel) report("clock_source", 64'(s), 64'(p.sel));
      if (h !== p.hr) report("osc_high_range", 64'(h), 64'(p.hr));
      if (a !== p.ach) report("achieved_freq", 64'(a), 64'(p.ach));
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [26:0] req_target_freq = 0;
   logic [24:0] req_osc_freq = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_use_pll;
   logic [9:0]  rsp_pll_mult;
   logic [8:0]  rsp_core_div;
   logic        rsp_clock_source;
   logic        rsp_osc_high_range;
   logic [27:0] rsp_achieved_freq;

   int send_idle = 0;
   int recv_idle = 0;
   int cycles = 0;
   divisor_scoreboard plan_board = new();

   pll_clock_divisor_calc_top i_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: random stall and checking of each accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         plan_board.check_response(rsp_use_pll, rsp_pll_mult, rsp_core_div,
                                   rsp_clock_source, rsp_osc_high_range,
                                   rsp_achieved_freq);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic send_word(logic [26:0] tgt, logic [24:0] osc);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid       <= 1;
      req_target_freq <= tgt;
      req_osc_freq    <= osc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      plan_board.note_request(tgt, osc);
   endtask

   task automatic send_random();
      logic [26:0] t;
      logic [24:0] o;
      case ($urandom_range(5))
         0: t = 27'($urandom);
         1: t = 27'($urandom_range(1000, 1));
         2: t = 27'($urandom_range(120000000, 96000000));
         default: t = 27'($urandom_range(120000000, 1));
      endcase
      case ($urandom_range(4))
         0: o = 0;
         1: o = 25'($urandom);
         2: o = 25'($urandom_range(25000000, 18000000));
         3: o = 25'($urandom_range(500, 1));
         default: o = 25'($urandom_range(25000000, 1));
      endcase
      send_word(t, o);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (plan_board.plan_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero target, field extremes, both PLL paths and saturation
      send_word(0, 0);
      send_word(1, 0);
      send_word(27'h7FFFFFF, 0);
      send_word(27'h7FFFFFF, 25'h1FFFFFF);
      send_word(1, 25'h1FFFFFF);
      send_word(120000000, 12000000);
      send_word(96000000, 12000000);
      send_word(96000001, 12000000);
      send_word(60000000, 25000000);
      send_word(100000000, 18000000);
      send_word(100000000, 18000001);
      send_word(2, 1);
      send_word(3, 1);
      send_word(120000000, 1);
      send_word(27'h7FFFFFF, 1);
      send_word(10000, 25000000);
      send_word(4000000, 0);
      send_word(4000001, 0);
      send_word(15625, 0);
      send_word(15600, 0);
      send_word(25000000, 25000000);
      send_word(1000, 500);
      drain();
      send_idle = 28; recv_idle = 48;
      repeat (240) send_random();
      drain();
      send_idle = 48; recv_idle = 28;
      repeat (240) send_random();
      send_idle = 0; recv_idle = 0;
      repeat (240) send_random();
      drain();
      repeat (80) @(posedge clock);
      if (plan_board.mismatches == 0 && plan_board.plan_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
